FILE: rtl/core/gbg_pkg.sv
// ----------------------------------------------------------------------------
// gbg_pkg: shared types for the 5x5 grey Gaussian blur
// Window geometry and the classified pixel word passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package gbg_pkg;

  localparam int WIN_DIM = 5;
  localparam int IDX_W   = 3;

  // One classified pixel: grey value plus where it lands in the window.
  typedef struct packed {
    logic [7:0]       grey;
    logic             full;   // part of a full 25-pixel load
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;    // used by full loads only
    logic             last;   // completes the group
  } gbg_item_t;

endpackage

`default_nettype wire

FILE: rtl/core/gaussian_blur_5x5_grey.sv
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_grey: 5x5 Gaussian blur of a grey-converted pixel stream
// Converts RGB pixels to grey, gathers them into a 5x5 window and emits the
// rounded 1-4-7-16-26-41 weighted average each time a pixel group completes.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload                          moves
//  --------  -----------------  -------------------------------  -----------
//  input     in_push / in_full  in_red, in_green, in_blue,       one pixel
//                               in_row_start
//  result    out_pop / out_empty out_blurred                     one value
//
//  Cycles: one pixel word per cycle while in_full is low. After the edge that
//  takes the group's last pixel, a result passes two grey stages, the classified-
//  word queue, the weight-group sums, the weighted sum and the result queue.
//  Reset: rst_n low clears the group position and all valid flags; the window
//  itself holds no reset value and needs no clearing pass.
//  Stalls: a full result queue holds the back end; the classified-word queue
//  then fills and in_full rises only when the front pipe is also full.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_blur_5x5_grey
  import gbg_pkg::*;
#(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [7:0] in_red,
  input  wire logic [7:0] in_green,
  input  wire logic [7:0] in_blue,
  input  wire logic       in_row_start,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [7:0]      out_blurred
);

  // classified words between front and back
  logic      mid_push, mid_full, mid_pop, mid_empty;
  gbg_item_t mid_wr_item, mid_rd_item;

  // results from the back end into the output queue
  logic       res_push, res_full;
  logic [7:0] res_blurred;

  // Front: take a pixel word, convert to grey, tag its window position.
  gbg_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .in_row_start (in_row_start),
    .q_push       (mid_push),
    .q_item       (mid_wr_item),
    .q_full       (mid_full)
  );

  // Decouple the two halves so each can stall on its own.
  gbg_fifo #(
    .WIDTH ($bits(gbg_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wr_item),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rd_item),
    .empty (mid_empty)
  );

  // Back: update the window, convolve when a group closes.
  gbg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (mid_empty),
    .q_item    (mid_rd_item),
    .q_pop     (mid_pop),
    .o_push    (res_push),
    .o_blurred (res_blurred),
    .o_full    (res_full)
  );

  // Hold finished results until the consumer pops them.
  gbg_fifo #(
    .WIDTH (8),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_blurred),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_blurred),
    .empty (out_empty)
  );

endmodule

`default_nettype wire

FILE: rtl/core/gbg_fifo.sv
// ----------------------------------------------------------------------------
// gbg_fifo: small synchronous word queue
// Register-array queue with a combinational head word.
// ----------------------------------------------------------------------------
`default_nettype none

module gbg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/gbg_front.sv
// ----------------------------------------------------------------------------
// gbg_front: pixel intake, grey conversion and group classification
// Two-stage pipe: weighted RGB sum, then exact divide by 1000.
// ----------------------------------------------------------------------------
`default_nettype none

module gbg_front
  import gbg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [7:0] in_red,
  input  wire logic [7:0] in_green,
  input  wire logic [7:0] in_blue,
  input  wire logic       in_row_start,
  output logic            q_push,
  output gbg_item_t       q_item,
  input  wire logic       q_full
);

  localparam logic [17:0] COEF_R    = 18'd299;
  localparam logic [17:0] COEF_G    = 18'd587;
  localparam logic [17:0] COEF_B    = 18'd114;
  localparam logic [17:0] ROUND_ADD = 18'd500;
  // floor(x/125) = (x * 33555) >> 22 for x below 2^15
  localparam logic [30:0] RECIP_125 = 31'd33555;
  localparam logic [4:0]  FULL_LAST = 5'd24;
  localparam logic [4:0]  COL_LAST  = 5'd4;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WIN_DIM - 1);

  logic             accept;
  logic             s1_ready, s2_ready;
  logic             s1_v_r, s2_v_r;
  logic [17:0]      s1_acc_r, acc_nxt;
  gbg_item_t        s1_item_r, s2_item_r, cls_nxt, s2_nxt;
  logic [30:0]      prod;

  logic [4:0]       cnt_r, cnt_nxt;
  logic [IDX_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic             full_load_r, full_load_nxt;
  logic             first;

  assign s2_ready = !s2_v_r || !q_full;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_full  = !s1_ready;
  assign accept   = in_push && s1_ready;
  assign q_push   = s2_v_r;
  assign q_item   = s2_item_r;

  assign acc_nxt = 18'(in_red) * COEF_R + 18'(in_green) * COEF_G
                 + 18'(in_blue) * COEF_B + ROUND_ADD;

  // Classify the pixel against the running group position.
  always_comb begin
    first          = (cnt_r == '0);
    full_load_nxt  = first ? in_row_start : full_load_r;
    cls_nxt        = '0;
    cls_nxt.full   = full_load_nxt;
    cls_nxt.row    = full_load_nxt ? row_r : cnt_r[IDX_W-1:0];
    cls_nxt.col    = col_r;
    cls_nxt.last   = full_load_nxt ? (cnt_r == FULL_LAST) : (cnt_r == COL_LAST);
    cnt_nxt        = cnt_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    if (accept) begin
      if (cls_nxt.last) begin
        cnt_nxt = '0;
        row_nxt = '0;
        col_nxt = '0;
      end else begin
        cnt_nxt = cnt_r + 5'd1;
        if (full_load_nxt) begin
          if (col_r == IDX_LAST) begin
            col_nxt = '0;
            row_nxt = row_r + IDX_W'(1);
          end else begin
            col_nxt = col_r + IDX_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      full_load_r <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      row_r <= row_nxt;
      col_r <= col_nxt;
      if (accept) begin
        full_load_r <= full_load_nxt;
      end
      if (s1_ready) begin
        s1_v_r <= accept;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  // divide by 8 by dropping bits, then by 125 through the reciprocal
  assign prod = 31'(s1_acc_r[17:3]) * RECIP_125;

  // carry the classified word forward with its finished grey value
  always_comb begin
    s2_nxt      = s1_item_r;
    s2_nxt.grey = prod[29:22];
  end

  always_ff @(posedge clk) begin
    if (s1_ready && accept) begin
      s1_acc_r  <= acc_nxt;
      s1_item_r <= cls_nxt;
    end
    if (s2_ready && s1_v_r) begin
      s2_item_r <= s2_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/gbg_back.sv
// ----------------------------------------------------------------------------
// gbg_back: window update and Gaussian convolution
// Writes classified pixels into the 5x5 window and convolves on group end.
// ----------------------------------------------------------------------------
`default_nettype none

module gbg_back
  import gbg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_empty,
  input  gbg_item_t       q_item,
  output logic            q_pop,
  output logic            o_push,
  output logic [7:0]      o_blurred,
  input  wire logic       o_full
);

  localparam logic [16:0] ROUND_HALF = 17'd136;
  // floor(x/273) = (x * 245823) >> 26 for x up to 80000
  localparam logic [34:0] RECIP_273  = 35'd245823;

  logic        en;
  logic [7:0]  win_r   [WIN_DIM][WIN_DIM];
  logic [7:0]  win_nxt [WIN_DIM][WIN_DIM];
  logic [10:0] s1_nxt, s4_nxt, s7_nxt, s16_nxt, s26_nxt, s41_nxt;
  logic [10:0] s1_r, s4_r, s7_r, s16_r, s26_r, s41_r;
  logic [16:0] sum_nxt, sum_r;
  logic        a_v_r, b_v_r;
  logic [34:0] prod;

  // one global enable: hold the whole back end while the result queue is full
  assign en     = !o_full;
  assign q_pop  = en && !q_empty;
  assign o_push = en && b_v_r;

  always_comb begin
    for (int r = 0; r < WIN_DIM; r++) begin
      for (int c = 0; c < WIN_DIM; c++) begin
        win_nxt[r][c] = win_r[r][c];
      end
    end
    if (q_pop) begin
      for (int r = 0; r < WIN_DIM; r++) begin
        if (q_item.full) begin
          for (int c = 0; c < WIN_DIM; c++) begin
            if (q_item.row == IDX_W'(r) && q_item.col == IDX_W'(c)) begin
              win_nxt[r][c] = q_item.grey;
            end
          end
        end else if (q_item.row == IDX_W'(r)) begin
          for (int c = 0; c < WIN_DIM - 1; c++) begin
            win_nxt[r][c] = win_r[r][c+1];
          end
          win_nxt[r][WIN_DIM-1] = q_item.grey;
        end
      end
    end
  end

  // group the taps by kernel weight (kernel is symmetric)
  always_comb begin
    s1_nxt  = 11'(win_nxt[0][0]) + 11'(win_nxt[0][4]) + 11'(win_nxt[4][0])
            + 11'(win_nxt[4][4]);
    s4_nxt  = 11'(win_nxt[0][1]) + 11'(win_nxt[0][3]) + 11'(win_nxt[1][0])
            + 11'(win_nxt[1][4]) + 11'(win_nxt[3][0]) + 11'(win_nxt[3][4])
            + 11'(win_nxt[4][1]) + 11'(win_nxt[4][3]);
    s7_nxt  = 11'(win_nxt[0][2]) + 11'(win_nxt[2][0]) + 11'(win_nxt[2][4])
            + 11'(win_nxt[4][2]);
    s16_nxt = 11'(win_nxt[1][1]) + 11'(win_nxt[1][3]) + 11'(win_nxt[3][1])
            + 11'(win_nxt[3][3]);
    s26_nxt = 11'(win_nxt[1][2]) + 11'(win_nxt[2][1]) + 11'(win_nxt[2][3])
            + 11'(win_nxt[3][2]);
    s41_nxt = 11'(win_nxt[2][2]);
  end

  assign sum_nxt = 17'(s1_r) + (17'(s4_r) << 2) + 17'(s7_r) * 17'd7
                 + (17'(s16_r) << 4) + 17'(s26_r) * 17'd26 + 17'(s41_r) * 17'd41;

  assign prod      = 35'(sum_r + ROUND_HALF) * RECIP_273;
  assign o_blurred = prod[33:26];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= q_pop && q_item.last;
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      win_r <= win_nxt;
    end
    if (en) begin
      s1_r  <= s1_nxt;
      s4_r  <= s4_nxt;
      s7_r  <= s7_nxt;
      s16_r <= s16_nxt;
      s26_r <= s26_nxt;
      s41_r <= s41_nxt;
      sum_r <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/gbg_checker.sv
// ----------------------------------------------------------------------------
// gbg_checker: port-level checks for the grey Gaussian blur
// Watches the top-level ports and is bound onto every instance.
// ----------------------------------------------------------------------------
`default_nettype none

module gbg_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_full,
  input wire logic       out_empty,
  input wire logic       out_pop,
  input wire logic [7:0] out_blurred
);

  // reset drops every pending result
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // reset leaves the front pipe open for the first pixel
  a_reset_open: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input blocked right after reset");

  // a waiting result stays until it is popped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty)
    else $error("waiting result dropped");

  // and its value does not change while it waits
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> $stable(out_blurred))
    else $error("waiting result changed");

endmodule

bind gaussian_blur_5x5_grey gbg_checker u_gbg_checker (.*);

`default_nettype wire

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 5x5 grey Gaussian blur
// Streams RGB pixel words in full-load and column-update groups, predicts
// each blurred value from a local copy of the window and checks the results
// in order, with random idle bursts on both the pixel and the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import gbg_pkg::*;

  localparam int FULL_PIXELS  = WIN_DIM * WIN_DIM;
  localparam int COL_PIXELS   = WIN_DIM;
  localparam int RAND_PIXELS  = 500;
  localparam int QUIET_TAIL   = 80;     // last pixel words sent with no idling
  localparam int DRAIN_CYCLES = 20;     // covers result latency plus queueing
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;

  // Kernel weights, row-major; they add up to KERNEL_SUM.
  localparam int unsigned KERNEL_SUM = 273;
  localparam int unsigned GAUSS_K [WIN_DIM][WIN_DIM] = '{
    '{1,  4,  7,  4, 1},
    '{4, 16, 26, 16, 4},
    '{7, 26, 41, 26, 7},
    '{4, 16, 26, 16, 4},
    '{1,  4,  7,  4, 1}
  };

  // One pending pixel word. drain_first holds it back until all results
  // already owed by the block have come out.
  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_start;
    bit         drain_first;
  } rgb_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic [7:0] in_red = '0;
  logic [7:0] in_green = '0;
  logic [7:0] in_blue = '0;
  logic       in_row_start = 1'b0;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [7:0] out_blurred;

  rgb_word_t  pixel_q[$];     // pixel words not yet taken by the block
  logic [7:0] blur_q[$];      // blurred values owed by the block, oldest first

  // Local picture of the block: the grey window and the group position.
  logic [7:0] grey_win [WIN_DIM][WIN_DIM];
  int         grp_pos = 0;
  bit         grp_full = 1'b0;

  int  n_full_loads = 0;
  int  n_col_updates = 0;
  int  n_queued = 0;
  int  n_taken = 0;
  int  n_checked = 0;
  int  n_errors = 0;
  int  cycle_cnt = 0;
  int  send_gap = 0;
  int  pop_gap = 0;

  gaussian_blur_5x5_grey u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .in_row_start (in_row_start),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_blurred  (out_blurred)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Weighted window average, rounded to the nearest integer.
  function automatic logic [7:0] blur_of_window();
    int unsigned acc;
    acc = 0;
    for (int v = 0; v < WIN_DIM; v++) begin
      for (int u = 0; u < WIN_DIM; u++) begin
        acc += int'(grey_win[v][u]) * GAUSS_K[v][u];
      end
    end
    return 8'((acc + KERNEL_SUM / 2) / KERNEL_SUM);
  endfunction

  // Advance the local window by one taken pixel word; owe a blurred value
  // whenever the word closes its group.
  task automatic take_pixel(input rgb_word_t px);
    int unsigned grey;
    grey = (299 * int'(px.red) + 587 * int'(px.green) + 114 * int'(px.blue) + 500)
           / 1000;
    // row_start only counts on the first word of a group
    if (grp_pos == 0) grp_full = px.row_start;
    if (grp_full) begin
      grey_win[grp_pos / WIN_DIM][grp_pos % WIN_DIM] = 8'(grey);
      grp_pos++;
      if (grp_pos == FULL_PIXELS) begin
        grp_pos = 0;
        blur_q.push_back(blur_of_window());
      end
    end else begin
      // shift this row left and drop the new pixel into the right column
      for (int c = 0; c < WIN_DIM - 1; c++) grey_win[grp_pos][c] = grey_win[grp_pos][c + 1];
      grey_win[grp_pos][WIN_DIM - 1] = 8'(grey);
      grp_pos++;
      if (grp_pos == COL_PIXELS) begin
        grp_pos = 0;
        blur_q.push_back(blur_of_window());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus generation
  // --------------------------------------------------------------------------

  // Channel level biased toward the extremes.
  function automatic logic [7:0] rand_level();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic rs, input bit drain);
    rgb_word_t px;
    px.red = r;
    px.green = g;
    px.blue = b;
    px.row_start = rs;
    px.drain_first = drain;
    pixel_q.push_back(px);
    n_queued++;
  endtask

  // One random group. Later words carry a stray row_start now and then,
  // which the block must ignore.
  task automatic queue_group(input bit full, input bit drain);
    int n;
    n = full ? FULL_PIXELS : COL_PIXELS;
    if (full) n_full_loads++;
    else n_col_updates++;
    for (int i = 0; i < n; i++) begin
      queue_pixel(rand_level(), rand_level(), rand_level(),
                  (i == 0) ? full : ($urandom_range(0, 3) == 0), drain && (i == 0));
    end
  endtask

  // Idle bursts are off in regular stretches so some phases run back to back,
  // and off for good near the end of the stream.
  function automatic bit idling_allowed();
    return pixel_q.size() > QUIET_TAIL && ((cycle_cnt / 64) % 3 != 2);
  endfunction

  // --------------------------------------------------------------------------
  // Pixel driver: take the accepted word, then pick the next one or idle
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    rgb_word_t px;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        px = pixel_q.pop_front();
        take_pixel(px);
        n_taken++;
      end
      if (send_gap > 0) begin
        send_gap--;
        in_push <= 1'b0;
      end else if (pixel_q.size() == 0 || (pixel_q[0].drain_first && blur_q.size() != 0)) begin
        // nothing left, or hold until the block has emptied out
        in_push <= 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 2);
        in_push <= 1'b0;
      end else begin
        in_push      <= 1'b1;
        in_red       <= pixel_q[0].red;
        in_green     <= pixel_q[0].green;
        in_blue      <= pixel_q[0].blue;
        in_row_start <= pixel_q[0].row_start;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: check the popped word, then decide whether to stall
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (blur_q.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("[%0t] unexpected result word: blurred=%0d", $realtime, out_blurred);
        end else begin
          want = blur_q.pop_front();
          n_checked++;
          if (out_blurred !== want) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("[%0t] blurred mismatch: expected %0d, got %0d",
                       $realtime, want, out_blurred);
          end
        end
      end
      if (pop_gap > 0) begin
        pop_gap--;
        out_pop <= 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
        pop_gap = $urandom_range(0, 2);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int mid_group;
    int n_groups;

    // Directed: a full load cycling through black, pure red, pure green,
    // pure blue and white, with a stray row_start flag inside the group.
    n_full_loads++;
    for (int i = 0; i < FULL_PIXELS; i++) begin
      case (i % 5)
        0: queue_pixel(8'h00, 8'h00, 8'h00, i == 0 || i == 7 || i == 13, 1'b0);
        1: queue_pixel(8'hFF, 8'h00, 8'h00, 1'b0, 1'b0);
        2: queue_pixel(8'h00, 8'hFF, 8'h00, 1'b0, 1'b0);
        3: queue_pixel(8'h00, 8'h00, 8'hFF, 1'b0, 1'b0);
        default: queue_pixel(8'hFF, 8'hFF, 8'hFF, i == 19, 1'b0);
      endcase
    end
    // Directed: a white column update with a stray row_start in the middle.
    n_col_updates++;
    for (int i = 0; i < COL_PIXELS; i++) queue_pixel(8'hFF, 8'hFF, 8'hFF, i == 2, 1'b0);

    // Random groups, mostly column updates. Drain the block before the random
    // part starts and again about halfway through.
    mid_group = RAND_PIXELS / 20;
    n_groups = 0;
    while (n_queued < RAND_PIXELS + FULL_PIXELS + COL_PIXELS) begin
      queue_group($urandom_range(0, 4) == 0, n_groups == 0 || n_groups == mid_group);
      n_groups++;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pixel_q.size() != 0 || blur_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d pixel words: %0d full loads, %0d column updates",
             n_taken, n_full_loads, n_col_updates);
    $display("%0d blurred values checked, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0 && blur_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
